// File: hdl/plc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plc_pkg
// Shared widths, codes and types of the password lock controller.
// ----------------------------------------------------------------------------
package plc_pkg;

	localparam int PWD_LEN   = 4;
	localparam int POS_W     = $clog2(PWD_LEN + 1);
	localparam int BYTE_W    = 8;
	localparam int OP_W      = 2;
	localparam int EV_W      = 3;
	localparam int INTV_W    = 16;
	localparam int TOG_W     = 8;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 16;

	localparam logic [INTV_W-1:0] INTV_RESET = INTV_W'(250);
	localparam logic [TOG_W-1:0]  TOG_RESET  = TOG_W'(6);

	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_EXIT  = 8'h65;
	localparam logic [BYTE_W-1:0] CH_EXITU = 8'h45;
	localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

	typedef enum logic [OP_W-1:0] {
		OP_CHAR   = 2'd0,
		OP_BUTTON = 2'd1,
		OP_TICK   = 2'd2,
		OP_START  = 2'd3
	} op_t;

	typedef enum logic [EV_W-1:0] {
		EV_NONE      = 3'd0,
		EV_EMPTY     = 3'd1,
		EV_CORRECT   = 3'd2,
		EV_INCORRECT = 3'd3,
		EV_UPDATED   = 3'd4,
		EV_EXITED    = 3'd5,
		EV_PROMPT    = 3'd6
	} ev_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLINK_INTV = 1'd0,
		REG_BLINK_TOG  = 1'd1
	} reg_idx_t;

	typedef logic [BYTE_W-1:0] byte_arr_t [PWD_LEN];

	typedef struct packed {
		logic echo;
		ev_t  ev;
		logic led;
		logic active;
		logic upd;
	} res_t;

endpackage
`default_nettype wire

// File: hdl/password_lock_controller_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// password_lock_controller_top
// Code lock: characters, button presses, millisecond ticks and start commands
// in; echo mask, event code, LED and mode flags out.
// ----------------------------------------------------------------------------
// The lock takes one item per clock while in_ready is high and gives exactly
// one result item for each. An item is held in an input register, the lock
// state is updated from it by a single pass of compare and counter logic, and
// the result lands in an output register. The result item is offered once its
// item has passed from the input register into the output register, and it
// leaves when the output side is ready. The output register decouples the two
// sides: a new item is accepted while a result waits, and only a full input
// register behind a stalled output holds in_ready low.
// The result fields show the state after the item has been applied. The
// blink registers (index 0: interval in ticks, index 1: number of toggles)
// are written through cfg_we/cfg_index/cfg_data and should be changed only
// while no item is in flight. The stored password resets to four ASCII '0'.
// ----------------------------------------------------------------------------
module password_lock_controller_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [plc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [plc_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [plc_pkg::OP_W-1:0]      operation,
	input  wire logic [plc_pkg::BYTE_W-1:0]    char_code,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               echo_star,
	output logic [plc_pkg::EV_W-1:0]           event_res,
	output logic                               led_on,
	output logic                               is_active,
	output logic                               in_update_mode
);
	import plc_pkg::*;

	logic              valid_s1;
	logic [OP_W-1:0]   op_s1;
	logic [BYTE_W-1:0] ch_s1;
	logic              advance;
	res_t              res;
	res_t              res_q;
	logic              out_valid_q;

	// advance the held item into the output register when that has room
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register: payload needs no reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1 <= operation;
			ch_s1 <= char_code;
		end
	end

	plc_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fire      (advance),
		.op_in     (op_s1),
		.ch_in     (ch_s1),
		.res       (res)
	);

	// output register: hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign echo_star      = res_q.echo;
	assign event_res      = res_q.ev;
	assign led_on         = res_q.led;
	assign is_active      = res_q.active;
	assign in_update_mode = res_q.upd;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with an empty output register");

	a_exit_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.ev == EV_EXITED |-> !res_q.active && !res_q.led)
		else $error("exit left the lock active or the LED lit");

	a_no_echo_on_submit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.echo |-> res_q.ev != EV_EMPTY && res_q.ev != EV_CORRECT
			&& res_q.ev != EV_INCORRECT && res_q.ev != EV_UPDATED)
		else $error("asterisk echoed for a carriage return");

	a_prompt_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.ev == EV_PROMPT |-> res_q.upd)
		else $error("change prompt without update mode");

	a_correct_lit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.ev == EV_CORRECT |-> res_q.led && !res_q.upd)
		else $error("correct entry did not light the LED");

endmodule
`default_nettype wire

// File: hdl/plc_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plc_step
// Lock state and the single-pass update that one item applies to it.
// ----------------------------------------------------------------------------
module plc_step (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [plc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [plc_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          fire,
	input  wire logic [plc_pkg::OP_W-1:0]      op_in,
	input  wire logic [plc_pkg::BYTE_W-1:0]    ch_in,
	output plc_pkg::res_t                      res
);
	import plc_pkg::*;

	logic [INTV_W-1:0] intv_q;
	logic [TOG_W-1:0]  tog_q;

	logic              active_q, upd_q, succ_q, led_q;
	logic [POS_W-1:0]  pos_q;
	byte_arr_t         entry_q, pwd_q;
	logic [INTV_W-1:0] timer_q;
	logic [TOG_W-1:0]  left_q;

	logic              active_d, upd_d, succ_d, led_d, echo_d;
	logic [POS_W-1:0]  pos_d;
	byte_arr_t         entry_d, pwd_d, term;
	logic [INTV_W-1:0] timer_d, timer_dec;
	logic [TOG_W-1:0]  left_d, left_dec;
	ev_t               ev_d;
	logic              match, done;
	op_t               op;

	assign op        = op_t'(op_in);
	assign timer_dec = timer_q - INTV_W'(1);
	assign left_dec  = left_q - TOG_W'(1);

	// entry with terminator placed after a short entry, and the strncmp check
	always_comb begin
		match = 1'b1;
		done  = 1'b0;
		for (int i = 0; i < PWD_LEN; i++) begin
			term[i] = (pos_q == POS_W'(i)) ? CH_NUL : entry_q[i];
		end
		for (int i = 0; i < PWD_LEN; i++) begin
			if (!done) begin
				if (term[i] != pwd_q[i]) begin
					match = 1'b0;
					done  = 1'b1;
				end else if (term[i] == CH_NUL) begin
					done = 1'b1;
				end
			end
		end
	end

	always_comb begin
		active_d = active_q;
		upd_d    = upd_q;
		succ_d   = succ_q;
		led_d    = led_q;
		pos_d    = pos_q;
		entry_d  = entry_q;
		pwd_d    = pwd_q;
		timer_d  = timer_q;
		left_d   = left_q;
		echo_d   = 1'b0;
		ev_d     = EV_NONE;
		if (op == OP_START) begin
			active_d = 1'b1;
			succ_d   = 1'b0;
			led_d    = 1'b0;
			pos_d    = '0;
			for (int i = 0; i < PWD_LEN; i++) entry_d[i] = CH_NUL;
		end else if (active_q) begin
			unique case (op)
				OP_CHAR: begin
					echo_d = !succ_q && (ch_in != CH_CR);
					if (ch_in == CH_EXIT || ch_in == CH_EXITU) begin
						active_d = 1'b0;
						led_d    = 1'b0;
						ev_d     = EV_EXITED;
					end else if (ch_in == CH_CR) begin
						if (pos_q == '0) begin
							ev_d = EV_EMPTY;
						end else begin
							entry_d = term;
							pos_d   = '0;
							if (!upd_q) begin
								if (match) begin
									succ_d = 1'b1;
									led_d  = 1'b1;
									ev_d   = EV_CORRECT;
								end else begin
									left_d  = tog_q;
									timer_d = intv_q;
									ev_d    = EV_INCORRECT;
								end
							end else begin
								pwd_d = term;
								led_d = 1'b0;
								upd_d = 1'b0;
								ev_d  = EV_UPDATED;
							end
						end
					end else if (pos_q < POS_W'(PWD_LEN)) begin
						for (int i = 0; i < PWD_LEN; i++) begin
							if (pos_q == POS_W'(i)) entry_d[i] = ch_in;
						end
						pos_d = pos_q + POS_W'(1);
					end
				end
				OP_BUTTON: begin
					if (upd_q) begin
						upd_d = 1'b0;
					end else begin
						upd_d = 1'b1;
						pos_d = '0;
						for (int i = 0; i < PWD_LEN; i++) entry_d[i] = CH_NUL;
						ev_d  = EV_PROMPT;
					end
				end
				OP_TICK: begin
					if (timer_q != '0) begin
						timer_d = timer_dec;
						if (timer_dec == '0 && left_q != '0) begin
							led_d  = !led_q;
							left_d = left_dec;
							if (left_dec != '0) timer_d = intv_q;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			intv_q <= INTV_RESET;
			tog_q  <= TOG_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_BLINK_INTV: intv_q <= cfg_data[INTV_W-1:0];
				REG_BLINK_TOG:  tog_q  <= cfg_data[TOG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			upd_q    <= 1'b0;
			succ_q   <= 1'b0;
			led_q    <= 1'b0;
			pos_q    <= '0;
			timer_q  <= '0;
			left_q   <= '0;
			for (int i = 0; i < PWD_LEN; i++) begin
				entry_q[i] <= CH_NUL;
				pwd_q[i]   <= CH_ZERO;
			end
		end else if (fire) begin
			active_q <= active_d;
			upd_q    <= upd_d;
			succ_q   <= succ_d;
			led_q    <= led_d;
			pos_q    <= pos_d;
			timer_q  <= timer_d;
			left_q   <= left_d;
			entry_q  <= entry_d;
			pwd_q    <= pwd_d;
		end
	end

	assign res = '{echo: echo_d, ev: ev_d, led: led_d, active: active_d, upd: upd_d};

endmodule
`default_nettype wire
